// File: rtl/sae_pkg.sv
// Shared types, codes, lookup tables and fixed-point helpers of the shaped envelope.
package sae_pkg;

  // Table geometry.
  localparam int LOG_TABLE_BITS = 8;
  localparam int TBL_N = (1 << LOG_TABLE_BITS) + 1;
  localparam int LSH = 24 - LOG_TABLE_BITS;
  localparam int ESH2 = 16 - LOG_TABLE_BITS;

  localparam logic [24:0] Q24_ONE = 25'h100_0000;

  // Stage codes.
  localparam logic [2:0] STG_OFF     = 3'd0;
  localparam logic [2:0] STG_ATTACK  = 3'd1;
  localparam logic [2:0] STG_DECAY   = 3'd2;
  localparam logic [2:0] STG_SUSTAIN = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ATTACK_STEP   = 3'd0;
  localparam logic [2:0] REG_DECAY_STEP    = 3'd1;
  localparam logic [2:0] REG_RELEASE_STEP  = 3'd2;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [2:0] REG_CURVE_SHAPE   = 3'd4;
  localparam logic [2:0] REG_TRIGGER_MODE  = 3'd5;

  // Operations of the shared arithmetic unit.
  localparam logic OP_POW = 1'b0;
  localparam logic OP_MUL = 1'b1;

  // Request to the arithmetic unit: pow(x, e / 2^(16 or 17)) or (x * y) >> 24.
  typedef struct packed {
    logic        start;
    logic        op;
    logic [24:0] x;
    logic [24:0] y;
    logic [17:0] e;
    logic        esh17;
  } sae_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [24:0] result;
  } sae_resp_t;

  typedef logic [16:0] log_tbl_t [TBL_N];
  typedef logic [24:0] exp_tbl_t [TBL_N];

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int t = 0; t < 32; t++) begin
      if (b > v) b = b >> 2;
    end
    for (int t = 0; t < 32; t++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i / 2^LOG_TABLE_BITS) in Q16, by repeated squaring.
  function automatic log_tbl_t build_log_tbl();
    log_tbl_t    tbl;
    logic [63:0] y;
    logic [16:0] r;
    for (int i = 0; i < TBL_N - 1; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        r = {r[15:0], 1'b0};
        if (y >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          y = y >> 1;
        end
      end
      tbl[i] = r;
    end
    tbl[TBL_N - 1] = 17'd65536;
    return tbl;
  endfunction

  // 2^(-i / 2^LOG_TABLE_BITS) in Q1.24, as a product of square-root powers.
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] hp [13];
    logic [63:0] prod;
    for (int j = 0; j < 13; j++) hp[j] = '0;
    hp[1] = isqrt(64'd1 << 59);
    for (int j = 2; j <= LOG_TABLE_BITS; j++) hp[j] = isqrt(hp[j - 1] << 30);
    for (int i = 0; i < TBL_N - 1; i++) begin
      prod = 64'd1 << 30;
      for (int j = 1; j <= LOG_TABLE_BITS; j++) begin
        if (((i >> (LOG_TABLE_BITS - j)) & 1) != 0)
          prod = (prod * hp[j] + (64'd1 << 29)) >> 30;
      end
      tbl[i] = 25'((prod + 64'd32) >> 6);
    end
    tbl[TBL_N - 1] = 25'h80_0000;
    return tbl;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();
  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  // A level in Q1.24; full scale maps to exactly 1.0.
  function automatic logic [24:0] level_to_q24(input logic [15:0] lvl);
    return (lvl == 16'hFFFF) ? Q24_ONE : {1'b0, lvl, 8'd0};
  endfunction

  // Q1.24 back to a rounded, saturated level.
  function automatic logic [15:0] q24_to_level(input logic [25:0] v);
    logic [25:0] r;
    r = (v + 26'd128) >> 8;
    if (v >= {1'b0, Q24_ONE}) return 16'hFFFF;
    if (r > 26'h00FFFF) return 16'hFFFF;
    return r[15:0];
  endfunction

endpackage

// File: rtl/sae_div.sv
// Restoring divider that forms the inverse attack exponent 2^33 / divisor.
module sae_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);
  import sae_pkg::*;

  localparam int DIV_STEPS = 17;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [17:0] d_r, d_nxt;
  logic [16:0] q_r, q_nxt;
  logic [18:0] rem2;

  assign rem2 = {rem_r, 1'b0};

  // One quotient bit per cycle; the remainder starts at 2^16, below any divisor.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = 18'h10000;
      d_nxt    = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem2 >= {1'b0, d_r}) begin
        rem_nxt = 18'(rem2 - {1'b0, d_r});
        q_nxt   = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = rem2[17:0];
        q_nxt   = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: rtl/sae_arith.sv
// Shared multiply-accumulate unit sequenced to compute table-based powers and scaled products.
module sae_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  sae_pkg::sae_req_t   req,
  output sae_pkg::sae_resp_t  resp
);
  import sae_pkg::*;

  localparam logic [3:0] PW_IDLE  = 4'd0;
  localparam logic [3:0] PW_NORM  = 4'd1;
  localparam logic [3:0] PW_L1    = 4'd2;
  localparam logic [3:0] PW_L2    = 4'd3;
  localparam logic [3:0] PW_G     = 4'd4;
  localparam logic [3:0] PW_P     = 4'd5;
  localparam logic [3:0] PW_SPLIT = 4'd6;
  localparam logic [3:0] PW_E1    = 4'd7;
  localparam logic [3:0] PW_E2    = 4'd8;
  localparam logic [3:0] PW_SH    = 4'd9;
  localparam logic [3:0] PW_MULD  = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [24:0] res_r, res_nxt;
  logic [24:0] x_r, x_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [17:0] e_r, e_nxt;
  logic        esh17_r, esh17_nxt;
  logic [20:0] g_r, g_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] f_r, f_nxt;
  logic [49:0] acc_r, acc_nxt;

  logic [24:0] mul_a, mul_b;
  logic [49:0] prod;
  logic        mac_en, mac_add;

  logic [LOG_TABLE_BITS-1:0] lidx, fidx;
  logic [LOG_TABLE_BITS:0]   lidx1, fidx1;
  logic [LSH-1:0]            lrem;
  logic [LSH:0]              lw0;
  logic [ESH2-1:0]           frem;
  logic [ESH2:0]             fw0;
  logic [16:0]               lg;
  logic [22:0]               p;
  logic [24:0]               v;

  // Table addressing from the normalized mantissa and from the exponent fraction.
  assign lidx  = x_r[23:LSH];
  assign lrem  = x_r[LSH-1:0];
  assign lidx1 = {1'b0, lidx} + (LOG_TABLE_BITS+1)'(1);
  assign lw0   = (LSH+1)'(1 << LSH) - {1'b0, lrem};
  assign fidx  = f_r[15:ESH2];
  assign frem  = f_r[ESH2-1:0];
  assign fidx1 = {1'b0, fidx} + (LOG_TABLE_BITS+1)'(1);
  assign fw0   = (ESH2+1)'(1 << ESH2) - {1'b0, frem};
  assign lg    = acc_r[LSH+16:LSH];
  assign p     = esh17_r ? {1'b0, acc_r[38:17]} : acc_r[38:16];
  assign v     = acc_r[ESH2+24:ESH2];

  // The one multiplier, fed by the sequencer.
  assign prod    = mul_a * mul_b;
  assign acc_nxt = (mac_add ? acc_r : 50'd0) + prod;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    x_nxt     = x_r;
    k_nxt     = k_r;
    e_nxt     = e_r;
    esh17_nxt = esh17_r;
    g_nxt     = g_r;
    n_nxt     = n_r;
    f_nxt     = f_r;
    mul_a     = '0;
    mul_b     = '0;
    mac_en    = 1'b0;
    mac_add   = 1'b0;
    unique case (state_r)
      PW_IDLE: begin
        if (req.start) begin
          if (req.op == OP_MUL) begin
            mul_a     = req.x;
            mul_b     = req.y;
            mac_en    = 1'b1;
            state_nxt = PW_MULD;
          end else if (req.x == 25'd0) begin
            res_nxt  = '0;
            done_nxt = 1'b1;
          end else if (req.x >= Q24_ONE) begin
            res_nxt  = Q24_ONE;
            done_nxt = 1'b1;
          end else begin
            x_nxt     = req.x;
            k_nxt     = '0;
            e_nxt     = req.e;
            esh17_nxt = req.esh17;
            state_nxt = PW_NORM;
          end
        end
      end
      // Shift the leading one up to bit 24, one place a cycle.
      PW_NORM: begin
        if (x_r[24]) begin
          state_nxt = PW_L1;
        end else begin
          x_nxt = {x_r[23:0], 1'b0};
          k_nxt = k_r + 5'd1;
        end
      end
      PW_L1: begin
        mul_a     = {8'd0, LOG_TBL[lidx]};
        mul_b     = 25'(lw0);
        mac_en    = 1'b1;
        state_nxt = PW_L2;
      end
      PW_L2: begin
        mul_a     = {8'd0, LOG_TBL[lidx1]};
        mul_b     = 25'(lrem);
        mac_en    = 1'b1;
        mac_add   = 1'b1;
        state_nxt = PW_G;
      end
      // Negated log2 of x in Q16.
      PW_G: begin
        g_nxt     = {k_r, 16'd0} - {4'd0, lg};
        state_nxt = PW_P;
      end
      PW_P: begin
        mul_a     = {4'd0, g_r};
        mul_b     = {7'd0, e_r};
        mac_en    = 1'b1;
        state_nxt = PW_SPLIT;
      end
      // Integer part is the final shift; a shift of 25 or more underflows to zero.
      PW_SPLIT: begin
        if (p[22:16] >= 7'd25) begin
          res_nxt   = '0;
          done_nxt  = 1'b1;
          state_nxt = PW_IDLE;
        end else begin
          n_nxt     = p[20:16];
          f_nxt     = p[15:0];
          state_nxt = PW_E1;
        end
      end
      PW_E1: begin
        mul_a     = EXP_TBL[fidx];
        mul_b     = 25'(fw0);
        mac_en    = 1'b1;
        state_nxt = PW_E2;
      end
      PW_E2: begin
        mul_a     = EXP_TBL[fidx1];
        mul_b     = 25'(frem);
        mac_en    = 1'b1;
        mac_add   = 1'b1;
        state_nxt = PW_SH;
      end
      PW_SH: begin
        res_nxt   = v >> n_r;
        done_nxt  = 1'b1;
        state_nxt = PW_IDLE;
      end
      PW_MULD: begin
        res_nxt   = acc_r[48:24];
        done_nxt  = 1'b1;
        state_nxt = PW_IDLE;
      end
      default: state_nxt = PW_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PW_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    res_r   <= res_nxt;
    x_r     <= x_nxt;
    k_r     <= k_nxt;
    e_r     <= e_nxt;
    esh17_r <= esh17_nxt;
    g_r     <= g_nxt;
    n_r     <= n_nxt;
    f_r     <= f_nxt;
    if (mac_en) acc_r <= acc_nxt;
  end

  assign resp.busy   = (state_r != PW_IDLE);
  assign resp.done   = done_r;
  assign resp.result = res_r;

endmodule

// File: rtl/shaped_adsr_envelope.sv
// Top level of the shaped ADSR envelope: stage sequencer, registers and output register.
//
// One input transaction per audio sample carries the gate level and the retrigger
// pulse; each one yields exactly one output transaction with the envelope level
// (Q0.16) and the stage code. Both channels use valid and stall.
// An input transaction is accepted only while the sequencer is idle; in_stall is
// high for the whole computation. The time from acceptance to a valid result is
// set by the shared multiply-accumulate unit: the normalizing shift of the power,
// four table products, the exponent product and, in decay and release, one
// scaling product. A retrigger in trigger mode adds the divider and a second
// power. Sustain and off use no arithmetic and go straight to the output.
// The output register parts the two sides: the next sample is accepted while a
// result still waits, and a stalled result holds its value; a finished sample
// waits for the output register to free up before the sequencer goes idle.
// Configuration writes go through cfg_wr_en, cfg_index and cfg_data; the user must
// make them only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) sets the stage to off, level, phase and release
// start to zero, steps to 1.0 and the other configuration registers to zero.
module shaped_adsr_envelope (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_gate_held,
  input  logic        in_retrigger_pulse,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_level,
  output logic [2:0]  out_stage_code,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  import sae_pkg::*;

  localparam logic [3:0] T_IDLE  = 4'd0;
  localparam logic [3:0] T_DIVW  = 4'd1;
  localparam logic [3:0] T_RPOWW = 4'd2;
  localparam logic [3:0] T_CTRL  = 4'd3;
  localparam logic [3:0] T_ADV   = 4'd4;
  localparam logic [3:0] T_SPOWW = 4'd5;
  localparam logic [3:0] T_MULW  = 4'd6;
  localparam logic [3:0] T_OUT   = 4'd7;

  logic [3:0]  state_r, state_nxt;
  logic        gate_r, gate_nxt;
  logic [2:0]  stage_r, stage_nxt;
  logic [15:0] level_r, level_nxt;
  logic [24:0] phase_r, phase_nxt;
  logic [15:0] rel_r, rel_nxt;

  logic [24:0] attack_step_r, decay_step_r, release_step_r;
  logic [15:0] sustain_r, shape_r;
  logic        trig_mode_r;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_level_r;
  logic [2:0]  out_stage_r;
  logic        out_free;
  logic        out_load;

  logic        div_start, div_done;
  logic [16:0] div_q;
  sae_req_t    req;
  sae_resp_t   resp;

  logic [17:0] e_att, e_dr;
  logic [24:0] s24;
  logic [24:0] step_sel;
  logic [25:0] adv_sum;
  logic [24:0] adv;

  logic [2:0]  ctl_stage;
  logic [24:0] ctl_phase;
  logic [15:0] ctl_level;
  logic [15:0] ctl_rel;

  sae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (e_att),
    .done     (div_done),
    .quotient (div_q)
  );

  sae_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .resp  (resp)
  );

  assign e_att = 18'h20000 - {2'd0, shape_r};
  assign e_dr  = 18'h10000 + {2'd0, shape_r};
  assign s24   = level_to_q24(sustain_r);

  // Phase advance for the current stage, saturating at 1.0.
  always_comb begin
    case (stage_r)
      STG_ATTACK: step_sel = attack_step_r;
      STG_DECAY:  step_sel = decay_step_r;
      default:    step_sel = release_step_r;
    endcase
  end
  assign adv_sum = {1'b0, phase_r} + {1'b0, step_sel};
  assign adv     = (adv_sum > {1'b0, Q24_ONE}) ? Q24_ONE : adv_sum[24:0];

  // Stage transitions taken at the start of a sample.
  always_comb begin
    ctl_stage = stage_r;
    ctl_phase = phase_r;
    ctl_level = level_r;
    ctl_rel   = rel_r;
    if (trig_mode_r) begin
      if (ctl_stage == STG_ATTACK && ctl_phase >= Q24_ONE) begin
        ctl_phase = '0;
        if (gate_r) begin
          ctl_stage = STG_DECAY;
        end else begin
          ctl_stage = STG_RELEASE;
          ctl_rel   = 16'hFFFF;
        end
      end else if (ctl_stage == STG_DECAY && ctl_phase >= Q24_ONE) begin
        ctl_phase = '0;
        if (gate_r) begin
          ctl_stage = STG_SUSTAIN;
        end else begin
          ctl_stage = STG_RELEASE;
          ctl_rel   = level_r;
        end
      end
      if (!gate_r) begin
        if (ctl_stage == STG_DECAY || ctl_stage == STG_SUSTAIN) begin
          ctl_phase = '0;
          ctl_stage = STG_RELEASE;
          ctl_rel   = level_r;
        end else if (ctl_stage == STG_RELEASE && ctl_phase >= Q24_ONE) begin
          ctl_phase = '0;
          ctl_stage = STG_OFF;
        end
      end
    end else if (gate_r) begin
      if (stage_r == STG_ATTACK) begin
        if (phase_r >= Q24_ONE) begin
          ctl_phase = '0;
          ctl_stage = STG_DECAY;
        end
      end else if (stage_r == STG_DECAY) begin
        if (phase_r >= Q24_ONE) begin
          ctl_phase = '0;
          ctl_stage = STG_SUSTAIN;
        end
      end else if (stage_r == STG_RELEASE) begin
        ctl_stage = STG_ATTACK;
        ctl_phase = level_to_q24(level_r);
      end else if (stage_r != STG_SUSTAIN) begin
        ctl_level = '0;
        ctl_phase = '0;
        ctl_stage = STG_ATTACK;
      end
    end else begin
      if (stage_r == STG_ATTACK || stage_r == STG_DECAY || stage_r == STG_SUSTAIN) begin
        ctl_phase = '0;
        ctl_stage = STG_RELEASE;
        ctl_rel   = level_r;
      end else if (stage_r == STG_RELEASE && phase_r >= Q24_ONE) begin
        ctl_phase = '0;
        ctl_stage = STG_OFF;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == T_OUT) && out_free;

  // Sample sequencer.
  always_comb begin
    state_nxt = state_r;
    gate_nxt  = gate_r;
    stage_nxt = stage_r;
    phase_nxt = phase_r;
    level_nxt = level_r;
    rel_nxt   = rel_r;
    div_start = 1'b0;
    req       = '0;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          gate_nxt = in_gate_held;
          if (trig_mode_r && in_retrigger_pulse) begin
            div_start = 1'b1;
            state_nxt = T_DIVW;
          end else begin
            state_nxt = T_CTRL;
          end
        end
      end
      // Retrigger: phase = pow(level, 1 / attack exponent).
      T_DIVW: begin
        if (div_done) begin
          req.start = 1'b1;
          req.op    = OP_POW;
          req.x     = level_to_q24(level_r);
          req.e     = {1'b0, div_q};
          req.esh17 = 1'b0;
          state_nxt = T_RPOWW;
        end
      end
      T_RPOWW: begin
        if (resp.done) begin
          phase_nxt = resp.result;
          stage_nxt = STG_ATTACK;
          state_nxt = T_CTRL;
        end
      end
      T_CTRL: begin
        stage_nxt = ctl_stage;
        phase_nxt = ctl_phase;
        level_nxt = ctl_level;
        rel_nxt   = ctl_rel;
        state_nxt = T_ADV;
      end
      // Advance the phase and start the curve for attack, decay and release; sustain and off set the level directly.
      T_ADV: begin
        state_nxt = T_SPOWW;
        case (stage_r) inside
          STG_ATTACK: begin
            phase_nxt = adv;
            req.start = 1'b1;
            req.op    = OP_POW;
            req.x     = adv;
            req.e     = e_att;
            req.esh17 = 1'b1;
          end
          STG_DECAY, STG_RELEASE: begin
            phase_nxt = adv;
            req.start = 1'b1;
            req.op    = OP_POW;
            req.x     = Q24_ONE - adv;
            req.e     = e_dr;
            req.esh17 = 1'b0;
          end
          STG_SUSTAIN: begin
            level_nxt = sustain_r;
            state_nxt = T_OUT;
          end
          default: begin
            stage_nxt = STG_OFF;
            level_nxt = '0;
            state_nxt = T_OUT;
          end
        endcase
      end
      T_SPOWW: begin
        if (resp.done) begin
          case (stage_r)
            STG_DECAY: begin
              req.start = 1'b1;
              req.op    = OP_MUL;
              req.x     = Q24_ONE - s24;
              req.y     = resp.result;
              state_nxt = T_MULW;
            end
            STG_RELEASE: begin
              req.start = 1'b1;
              req.op    = OP_MUL;
              req.x     = level_to_q24(rel_r);
              req.y     = resp.result;
              state_nxt = T_MULW;
            end
            default: begin
              level_nxt = q24_to_level({1'b0, resp.result});
              state_nxt = T_OUT;
            end
          endcase
        end
      end
      T_MULW: begin
        if (resp.done) begin
          case (stage_r)
            STG_DECAY: level_nxt = q24_to_level({1'b0, s24} + {1'b0, resp.result});
            default:   level_nxt = q24_to_level({1'b0, resp.result});
          endcase
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (out_free) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      gate_r      <= 1'b0;
      stage_r     <= STG_OFF;
      level_r     <= '0;
      phase_r     <= '0;
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      stage_r     <= stage_nxt;
      level_r     <= level_nxt;
      phase_r     <= phase_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_level_r <= level_r;
      out_stage_r <= stage_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_step_r  <= Q24_ONE;
      decay_step_r   <= Q24_ONE;
      release_step_r <= Q24_ONE;
      sustain_r      <= '0;
      shape_r        <= '0;
      trig_mode_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ATTACK_STEP:   attack_step_r  <= cfg_data;
        REG_DECAY_STEP:    decay_step_r   <= cfg_data;
        REG_RELEASE_STEP:  release_step_r <= cfg_data;
        REG_SUSTAIN_LEVEL: sustain_r      <= cfg_data[15:0];
        REG_CURVE_SHAPE:   shape_r        <= cfg_data[15:0];
        REG_TRIGGER_MODE:  trig_mode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall       = (state_r != T_IDLE);
  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_stage_code = out_stage_r;

`ifndef SYNTHESIS
  // The phase never runs past 1.0.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= Q24_ONE) else $error("phase above 1.0");

  // The arithmetic unit is only started while it is idle.
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !resp.busy) else $error("arithmetic request while busy");

  // The divider finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == T_DIVW) else $error("divider result not awaited");

  // A delivered stage code is always a real stage.
  a_out_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_stage_r <= STG_RELEASE) else $error("bad stage code");
`endif

endmodule

// File: sim/envelope_checker.sv
// Checker for the shaped envelope: watches the channels, predicts each sample and compares.
`timescale 1ns / 100ps

module envelope_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_gate_held,
  input  logic        in_retrigger_pulse,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_level,
  input  logic [2:0]  out_stage_code,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data,
  output int          errors,
  output int          pending
);
  import sae_pkg::*;

  localparam int NTBL = (1 << LOG_TABLE_BITS) + 1;
  localparam int FSH = 24 - LOG_TABLE_BITS;
  localparam int XSH = 16 - LOG_TABLE_BITS;
  localparam logic [63:0] ONE = 64'd1 << 24;

  typedef struct packed {
    logic [15:0] level;
    logic [2:0]  stage;
  } env_sample_t;

  env_sample_t expected_samples[$];

  logic [63:0] log2_tbl[NTBL];
  logic [63:0] exp2_tbl[NTBL];

  // Configuration copy.
  logic [63:0] atk_step, dec_step, rel_step, sus_level, shape;
  logic        trig_mode;

  // Envelope state copy.
  logic [2:0]  env_stage;
  logic [63:0] env_level, env_phase, rel_start;

  function automatic logic [63:0] root64(input logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Log2 and exp2 tables, built the same way the hardware ones are specified.
  initial begin
    logic [63:0] hp[13];
    logic [63:0] y, prod, r;
    hp[1] = root64(64'd1 << 59);
    for (int j = 2; j <= LOG_TABLE_BITS; j++) hp[j] = root64(hp[j - 1] << 30);
    for (int i = 0; i < NTBL - 1; i++) begin
      y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = 0;
      prod = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          r = r | 1;
          y = y >> 1;
        end
      end
      log2_tbl[i] = r;
      for (int j = 1; j <= LOG_TABLE_BITS; j++)
        if (((i >> (LOG_TABLE_BITS - j)) & 1) != 0)
          prod = (prod * hp[j] + (64'd1 << 29)) >> 30;
      exp2_tbl[i] = (prod + 32) >> 6;
    end
    log2_tbl[NTBL - 1] = 65536;
    exp2_tbl[NTBL - 1] = ONE >> 1;
  end

  function automatic logic [63:0] lvl_q24(input logic [63:0] l);
    return (l[15:0] == 16'hFFFF) ? ONE : 64'(l[15:0]) << 8;
  endfunction

  function automatic logic [63:0] q24_lvl(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 128) >> 8;
    if (v >= ONE || r > 64'hFFFF) return 64'hFFFF;
    return r;
  endfunction

  // pow(x, e / 2^esh) on Q1.24 via interpolated tables.
  function automatic logic [63:0] curve_pow(input logic [63:0] x, input logic [63:0] e,
                                            input int esh);
    int          top;
    logic [63:0] frac, idx, rem, lg, g, p, n, f, v;
    if (x == 0) return 0;
    if (x >= ONE) return ONE;
    top = 23;
    while (x[top] == 1'b0) top--;
    frac = (x << (24 - top)) & (ONE - 1);
    idx = frac >> FSH;
    rem = frac & ((64'd1 << FSH) - 1);
    lg = (log2_tbl[idx] * ((64'd1 << FSH) - rem) + log2_tbl[idx + 1] * rem) >> FSH;
    g = (64'(24 - top) << 16) - lg;
    p = (g * e) >> esh;
    n = p >> 16;
    if (n >= 25) return 0;
    f = p & 64'hFFFF;
    idx = f >> XSH;
    rem = f & ((64'd1 << XSH) - 1);
    v = (exp2_tbl[idx] * ((64'd1 << XSH) - rem) + exp2_tbl[idx + 1] * rem) >> XSH;
    return v >> n;
  endfunction

  function automatic logic [63:0] phase_next(input logic [63:0] step);
    logic [63:0] p;
    p = env_phase + step;
    return (p > ONE) ? ONE : p;
  endfunction

  task automatic enter_release(input logic [63:0] from_level);
    env_phase = 0;
    env_stage = STG_RELEASE;
    rel_start = from_level;
  endtask

  // Advance the envelope by one sample and return the expected output.
  task automatic predict_sample(input logic gate, input logic pulse, output env_sample_t res);
    logic [63:0] e_att, e_dr, c, s24;
    e_att = 131072 - shape;
    e_dr = 65536 + shape;
    if (trig_mode) begin
      if (pulse) begin
        env_stage = STG_ATTACK;
        env_phase = curve_pow(lvl_q24(env_level), (64'd131072 << 16) / e_att, 16);
      end
      if (env_stage == STG_ATTACK && env_phase >= ONE) begin
        if (gate) begin
          env_phase = 0;
          env_stage = STG_DECAY;
        end else enter_release(64'hFFFF);
      end else if (env_stage == STG_DECAY && env_phase >= ONE) begin
        if (gate) begin
          env_phase = 0;
          env_stage = STG_SUSTAIN;
        end else enter_release(env_level);
      end
      if (!gate) begin
        if (env_stage == STG_DECAY || env_stage == STG_SUSTAIN) enter_release(env_level);
        else if (env_stage == STG_RELEASE && env_phase >= ONE) begin
          env_stage = STG_OFF;
          env_phase = 0;
        end
      end
    end else if (gate) begin
      if (env_stage == STG_ATTACK) begin
        if (env_phase >= ONE) begin
          env_phase = 0;
          env_stage = STG_DECAY;
        end
      end else if (env_stage == STG_DECAY) begin
        if (env_phase >= ONE) begin
          env_phase = 0;
          env_stage = STG_SUSTAIN;
        end
      end else if (env_stage == STG_RELEASE) begin
        env_stage = STG_ATTACK;
        env_phase = lvl_q24(env_level);
      end else if (env_stage != STG_SUSTAIN) begin
        env_level = 0;
        env_phase = 0;
        env_stage = STG_ATTACK;
      end
    end else begin
      if (env_stage == STG_ATTACK || env_stage == STG_DECAY || env_stage == STG_SUSTAIN)
        enter_release(env_level);
      else if (env_stage == STG_RELEASE && env_phase >= ONE) begin
        env_stage = STG_OFF;
        env_phase = 0;
      end
    end

    case (env_stage)
      STG_ATTACK: begin
        env_phase = phase_next(atk_step);
        env_level = q24_lvl(curve_pow(env_phase, e_att, 17));
      end
      STG_DECAY: begin
        env_phase = phase_next(dec_step);
        c = curve_pow(ONE - env_phase, e_dr, 16);
        s24 = lvl_q24(sus_level);
        env_level = q24_lvl(s24 + (((ONE - s24) * c) >> 24));
      end
      STG_SUSTAIN: env_level = sus_level;
      STG_RELEASE: begin
        env_phase = phase_next(rel_step);
        c = curve_pow(ONE - env_phase, e_dr, 16);
        env_level = q24_lvl((lvl_q24(rel_start) * c) >> 24);
      end
      default: begin
        env_stage = STG_OFF;
        env_level = 0;
      end
    endcase
    res.level = env_level[15:0];
    res.stage = env_stage;
  endtask

  // Track configuration, predict accepted samples and compare accepted results.
  always @(posedge clk) begin
    env_sample_t exp_s, got_s;
    if (!rst_n) begin
      atk_step = ONE;
      dec_step = ONE;
      rel_step = ONE;
      sus_level = 0;
      shape = 0;
      trig_mode = 1'b0;
      env_stage = STG_OFF;
      env_level = 0;
      env_phase = 0;
      rel_start = 0;
      expected_samples.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ATTACK_STEP:   atk_step = cfg_data;
          REG_DECAY_STEP:    dec_step = cfg_data;
          REG_RELEASE_STEP:  rel_step = cfg_data;
          REG_SUSTAIN_LEVEL: sus_level = cfg_data[15:0];
          REG_CURVE_SHAPE:   shape = cfg_data[15:0];
          REG_TRIGGER_MODE:  trig_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got_s.level = out_level;
        got_s.stage = out_stage_code;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result transaction level %0d stage %0d",
                   $time, out_level, out_stage_code);
          errors++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (got_s.level !== exp_s.level) begin
            $display("%0t: level mismatch expected %0d actual %0d",
                     $time, exp_s.level, got_s.level);
            errors++;
          end
          if (got_s.stage !== exp_s.stage) begin
            $display("%0t: stage mismatch expected %0d actual %0d",
                     $time, exp_s.stage, got_s.stage);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_sample(in_gate_held, in_retrigger_pulse, exp_s);
        expected_samples.push_back(exp_s);
      end
      pending = expected_samples.size();
    end
  end

endmodule

// File: sim/shaped_adsr_envelope_tb.sv
// Testbench top of the shaped envelope: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module shaped_adsr_envelope_tb;
  import sae_pkg::*;

  localparam logic [24:0] STEP_ONE = 25'h100_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_gate_held = 1'b0;
  logic        in_retrigger_pulse = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_level;
  logic [2:0]  out_stage_code;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_ATTACK_STEP;
  logic [24:0] cfg_data = '0;
  int          errors;
  int          pending;
  bit          quiet = 1'b0;

  always #4 clk = ~clk;

  shaped_adsr_envelope u_dut (.*);

  envelope_checker u_checker (.*);

  // Receiver stalls in random bursts unless the run is in its quiet part.
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_stall = 1'b0;
    end
  end

  // Offer one sample and hold it until the transaction is taken.
  task automatic send_sample(input logic gate, input logic pulse);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_gate_held = gate;
    in_retrigger_pulse = pulse;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write a register once every result is in and the sequencer has settled.
  task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [24:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 25'd0;
      1: return STEP_ONE;
      2: return 25'($urandom_range(1, 25'h1FFFF));
      3: return 25'($urandom_range(25'h20000, 25'hFFFFFF));
      default: return 25'($urandom_range(25'h4000, 25'h100000));
    endcase
  endfunction

  task automatic set_all(input logic [24:0] a, input logic [24:0] d, input logic [24:0] r,
                         input logic [15:0] s, input logic [15:0] sh, input logic m);
    write_reg(REG_ATTACK_STEP, a);
    write_reg(REG_DECAY_STEP, d);
    write_reg(REG_RELEASE_STEP, r);
    write_reg(REG_SUSTAIN_LEVEL, {9'd0, s});
    write_reg(REG_CURVE_SHAPE, {9'd0, sh});
    write_reg(REG_TRIGGER_MODE, {24'd0, m});
  endtask

  // Gate sequences with pulses on rising edges, and some noise pulses.
  task automatic gate_phase(input int n);
    int   sent;
    int   seg;
    logic gate;
    logic pulse;
    sent = 0;
    gate = 1'b0;
    while (sent < n) begin
      gate = ~gate;
      seg = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int i = 0; i < seg && sent < n; i++) begin
        pulse = gate && i == 0;
        if ($urandom_range(0, 9) == 0) pulse = 1'($urandom_range(0, 1));
        send_sample(gate, pulse);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: default gate mode, full steps, then retrigger ignored and re-attack.
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    set_all(25'h40_0000, 25'h40_0000, 25'h20_0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    // Trigger mode: pulse with gate low, attack running through, zero step.
    set_all(25'h60_0000, 25'd0, 25'h80_0000, 16'h8000, 16'd0, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b0);

    // Random phases over many settings; the final one runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      set_all(pick_step(), pick_step(), pick_step(),
              ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF)),
              ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 16'hFFFF)),
              ph[0]);
      gate_phase(240);
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("PASS shaped_adsr_envelope");
    end else begin
      $display("FAIL shaped_adsr_envelope");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("FAIL shaped_adsr_envelope");
    $finish;
  end

endmodule

// File: files.f
rtl/sae_pkg.sv
rtl/sae_div.sv
rtl/sae_arith.sv
rtl/shaped_adsr_envelope.sv
sim/envelope_checker.sv
sim/shaped_adsr_envelope_tb.sv
